// File: src/flpf_pkg.sv
package flpf_pkg;

  // built size defaults
  localparam int DEPTH_DEF  = 16;
  localparam int LEVELS_DEF = 5;

  // fixed field widths
  localparam int DATA_W     = 16;
  localparam int CAP_W      = 5;
  localparam int FUNC_W     = 2;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_THR    = 4;

  // register reset values
  localparam logic [CAP_W-1:0]         CAP_RST  = 5'd16;
  localparam logic signed [DATA_W-1:0] THR2_RST = 16'sd20;
  localparam logic signed [DATA_W-1:0] THR3_RST = 16'sd30;
  localparam logic signed [DATA_W-1:0] THR4_RST = 16'sd40;
  localparam logic signed [DATA_W-1:0] THR5_RST = 16'sd50;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_POP  = 2'd1,
    FUNC_PEEK = 2'd2
  } func_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY = 3'd0,
    CFG_THR2     = 3'd1,
    CFG_THR3     = 3'd2,
    CFG_THR4     = 3'd3,
    CFG_THR5     = 3'd4
  } cfg_idx_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_READ = 2'd2,
    ST_LOAD = 2'd3
  } ctrl_state_t;

  // payload of one input transaction
  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic signed [DATA_W-1:0]  value;
  } in_item_t;

  // payload of one result transaction
  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic                      is_empty;
    logic signed [DATA_W-1:0]  head_value;
    logic signed [DATA_W-1:0]  tail_value;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic in_load;
    logic exec;
    logic read;
    logic out_load;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

// File: src/flpf_ctrl.sv
module flpf_ctrl import flpf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  dp_status_t dp_stat,
  output logic       in_stall,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_READ;
      ST_READ: state_nxt = ST_LOAD;
      ST_LOAD: if (!dp_stat.out_busy) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.in_load = in_valid;
      end
      ST_EXEC: cmd.exec = 1'b1;
      ST_READ: cmd.read = 1'b1;
      ST_LOAD: cmd.out_load = !dp_stat.out_busy;
      default: in_stall = 1'b1;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: src/flpf_dpath.sv
module flpf_dpath import flpf_pkg::*; #(
  parameter int DEPTH  = DEPTH_DEF,
  parameter int LEVELS = LEVELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            dp_stat,
  input  in_item_t              in_data,
  input  logic                  out_stall,
  output logic                  out_valid,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(LEVELS);
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  // configuration registers
  logic [CAP_W-1:0]         cap_r;
  logic signed [DATA_W-1:0] thr_r [NUM_THR];

  // queue state
  logic [IDX_W-1:0] head_r [LEVELS];
  logic [IDX_W-1:0] tail_r [LEVELS];
  logic [OCC_W-1:0] occ_r  [LEVELS];
  logic [IDX_W-1:0] head_nxt [LEVELS];
  logic [IDX_W-1:0] tail_nxt [LEVELS];
  logic [OCC_W-1:0] occ_nxt  [LEVELS];

  logic signed [DATA_W-1:0] mem [LEVELS][DEPTH];

  in_item_t                 item_r;
  logic [STAT_W-1:0]        status_r, status_nxt;
  logic signed [DATA_W-1:0] rd_head_r, rd_tail_r;
  logic                     empty_r;
  logic                     out_valid_r;
  out_item_t                out_r;

  logic [2:0]       raw_lvl;
  logic [LVL_W-1:0] push_lvl;
  logic [CMP_W-1:0] cap_ext, usable;
  logic             full;
  logic             mem_we;
  logic [LVL_W-1:0] hi_lvl, lo_lvl;
  logic             any_occ;
  logic [IDX_W-1:0] tail_prev;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= CAP_RST;
      thr_r[0] <= THR2_RST;
      thr_r[1] <= THR3_RST;
      thr_r[2] <= THR4_RST;
      thr_r[3] <= THR5_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAPACITY: cap_r    <= cfg_wdata[CAP_W-1:0];
        CFG_THR2:     thr_r[0] <= $signed(cfg_wdata);
        CFG_THR3:     thr_r[1] <= $signed(cfg_wdata);
        CFG_THR4:     thr_r[2] <= $signed(cfg_wdata);
        CFG_THR5:     thr_r[3] <= $signed(cfg_wdata);
        default:      ;
      endcase
    end
  end

  // level choice, highest threshold first, saturated to the last level
  always_comb begin
    if ($signed(item_r.value) > thr_r[3])      raw_lvl = 3'd4;
    else if ($signed(item_r.value) > thr_r[2]) raw_lvl = 3'd3;
    else if ($signed(item_r.value) > thr_r[1]) raw_lvl = 3'd2;
    else if ($signed(item_r.value) > thr_r[0]) raw_lvl = 3'd1;
    else                                       raw_lvl = 3'd0;
    if (raw_lvl > 3'(LEVELS - 1)) push_lvl = LVL_W'(LEVELS - 1);
    else                          push_lvl = LVL_W'(raw_lvl);
  end

  // usable capacity, clamped to one and to the built depth
  always_comb begin
    cap_ext = CMP_W'(cap_r);
    if (cap_r == '0)                  usable = CMP_W'(1);
    else if (cap_ext > CMP_W'(DEPTH)) usable = CMP_W'(DEPTH);
    else                              usable = cap_ext;
    full = CMP_W'(occ_r[push_lvl]) >= usable;
  end

  // highest and lowest non-empty levels
  always_comb begin
    hi_lvl  = '0;
    lo_lvl  = '0;
    any_occ = 1'b0;
    for (int l = 0; l < LEVELS; l++) begin
      if (occ_r[l] != '0) begin
        hi_lvl  = LVL_W'(l);
        any_occ = 1'b1;
      end
    end
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (occ_r[l] != '0) lo_lvl = LVL_W'(l);
    end
  end

  // newest entry position of the lowest level
  always_comb begin
    if (tail_r[lo_lvl] == '0) tail_prev = IDX_W'(DEPTH - 1);
    else                      tail_prev = tail_r[lo_lvl] - IDX_W'(1);
  end

  // operation execute
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    occ_nxt    = occ_r;
    status_nxt = status_r;
    mem_we     = 1'b0;
    if (cmd.exec) begin
      status_nxt = STAT_OK;
      case (item_r.func)
        FUNC_PUSH: begin
          if (full) begin
            status_nxt = STAT_OVERFLOW;
          end else begin
            mem_we = 1'b1;
            if (tail_r[push_lvl] == IDX_W'(DEPTH - 1)) tail_nxt[push_lvl] = '0;
            else tail_nxt[push_lvl] = tail_r[push_lvl] + IDX_W'(1);
            occ_nxt[push_lvl] = occ_r[push_lvl] + OCC_W'(1);
          end
        end
        FUNC_POP: begin
          if (!any_occ) begin
            status_nxt = STAT_UNDERFLOW;
          end else begin
            if (head_r[hi_lvl] == IDX_W'(DEPTH - 1)) head_nxt[hi_lvl] = '0;
            else head_nxt[hi_lvl] = head_r[hi_lvl] + IDX_W'(1);
            occ_nxt[hi_lvl] = occ_r[hi_lvl] - OCC_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // queue state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < LEVELS; l++) begin
        head_r[l] <= '0;
        tail_r[l] <= '0;
        occ_r[l]  <= '0;
      end
      status_r <= STAT_OK;
    end else begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      occ_r    <= occ_nxt;
      status_r <= status_nxt;
    end
  end

  // entry memory, one write and two registered reads
  always_ff @(posedge clk) begin
    if (mem_we) mem[push_lvl][tail_r[push_lvl]] <= item_r.value;
    if (cmd.read) begin
      rd_head_r <= mem[hi_lvl][head_r[hi_lvl]];
      rd_tail_r <= mem[lo_lvl][tail_prev];
      empty_r   <= !any_occ;
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.in_load) item_r <= in_data;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.status     <= status_r;
      out_r.is_empty   <= empty_r;
      out_r.head_value <= empty_r ? '0 : rd_head_r;
      out_r.tail_value <= empty_r ? '0 : rd_tail_r;
    end
  end

  assign dp_stat.out_busy = out_valid_r && out_stall;
  assign out_valid        = out_valid_r;
  assign out_data         = out_r;

endmodule

// File: src/five_level_priority_fifo.sv
// five-level priority queue: push, pop of the highest level, peek
// result: out_valid is set from the output register after the output load step
// sequence: the controller steps each transaction through accept, execute,
//   memory read, output load (held while the output stalls); in_stall is high until idle
// reset: synchronous active low, all levels empty, registers to defaults;
//   entry memory is not cleared and needs no clearing pass
module five_level_priority_fifo import flpf_pkg::*; #(
  parameter int DEPTH  = DEPTH_DEF,
  parameter int LEVELS = LEVELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_stat;

  // sequencing
  flpf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .dp_stat  (dp_stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // queue storage and result path
  flpf_dpath #(
    .DEPTH  (DEPTH),
    .LEVELS (LEVELS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .dp_stat   (dp_stat),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule
